FILE: design/hcs_pkg.sv
// Package for the Hermite curve sampler: payload types, weight table and divider constants.
`timescale 1ns / 1ps

package hcs_pkg;

    localparam int AXES = 3;

    // Sample index within a segment: 0..8 are the interior points, the last is the
    // control point itself (t = 1).
    localparam logic [3:0] LAST_IDX = 4'd9;

    // Weights are t, t^2 and t^3 scaled by a common denominator of 1000.
    localparam int WEIGHT_BITS = 10;
    localparam logic signed [47:0] WEIGHT_P0 = 48'sd1000;

    // Rounding offset and saturation thresholds on the magnitude plus offset.
    localparam logic [47:0] ROUND_HALF = 48'd500;
    localparam logic [47:0] SAT_POS    = 48'd1000 * (48'd1 << 31);
    localparam logic [47:0] SAT_NEG    = 48'd1000 * ((48'd1 << 31) + 48'd1);

    // Division by 1000 is a shift by three and a division by 125 done in two
    // reciprocal steps on the upper and lower halves of the shifted magnitude.
    localparam logic [6:0]  DIV_Q     = 7'd125;
    localparam int          R1_SHIFT  = 26;
    localparam int          R2_SHIFT  = 33;
    localparam logic [19:0] R1        = 20'((64'd1 << R1_SHIFT) / 64'd125);
    localparam logic [26:0] R2        = 27'((64'd1 << R2_SHIFT) / 64'd125);

    typedef struct packed {
        logic               start_curve;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               is_control;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w1;
        logic [WEIGHT_BITS-1:0] w2;
        logic [WEIGHT_BITS-1:0] w3;
    } t_weights;

    // 100(k+1), 10(k+1)^2, (k+1)^3 for k = 0..8; the control point uses t = 1 throughout.
    function automatic t_weights hcs_weights(input logic [3:0] k);
        t_weights w;
        case (k)
            4'd0:    w = '{w1: 10'd100, w2: 10'd10,  w3: 10'd1};
            4'd1:    w = '{w1: 10'd200, w2: 10'd40,  w3: 10'd8};
            4'd2:    w = '{w1: 10'd300, w2: 10'd90,  w3: 10'd27};
            4'd3:    w = '{w1: 10'd400, w2: 10'd160, w3: 10'd64};
            4'd4:    w = '{w1: 10'd500, w2: 10'd250, w3: 10'd125};
            4'd5:    w = '{w1: 10'd600, w2: 10'd360, w3: 10'd216};
            4'd6:    w = '{w1: 10'd700, w2: 10'd490, w3: 10'd343};
            4'd7:    w = '{w1: 10'd800, w2: 10'd640, w3: 10'd512};
            4'd8:    w = '{w1: 10'd900, w2: 10'd810, w3: 10'd729};
            default: w = '{w1: 10'd1000, w2: 10'd1000, w3: 10'd1000};
        endcase
        return w;
    endfunction

endpackage

FILE: design/hermite_curve_sampler.sv
// Top level of the Hermite curve sampler: segment setup, sample sequencer and arithmetic pipeline.
`timescale 1ns / 1ps

// Cubic Hermite curve sampler.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one control point with its
// tangent per transfer. Output channel (o_out_valid / i_out_ready / o_out_data) gives
// curve points. A point with start_curve set, or the first point after reset, yields
// one result: the point itself. Any other point yields nine interior samples of the
// segment from the previous point, then the point itself, flagged is_control and
// last_of_run.
// Throughput: one result per cycle while the receiver holds i_out_ready high; the
// sample sequencer on the item register sets this rate, and the next item is taken
// in the cycle its last sample is issued.
// The six-stage pipeline behind it (weighted sums, rounding division by 1000 and
// saturation) keeps filling while a result waits, and stalls stage by stage from the
// output register back when the receiver holds i_out_ready low; nothing is dropped.
// Reset (synchronous, active low) empties the pipeline and forgets the previous point.
module hermite_curve_sampler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hcs_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hcs_pkg::t_out_item o_out_data
);
    import hcs_pkg::*;

    logic signed [31:0] in_pos [AXES];
    logic signed [31:0] in_tan [AXES];
    logic               in_xfer;
    logic               seg;
    logic               issue;
    logic               issue_last;

    // Previous control point.
    logic signed [31:0] r_prev_pos [AXES];
    logic signed [31:0] r_prev_tan [AXES];
    logic               r_have_prev;

    // Item register: segment coefficients and the sample index.
    logic               r_it_valid;
    logic [3:0]         r_it_k;
    logic signed [31:0] r_it_p0 [AXES];
    logic signed [31:0] r_it_t0 [AXES];
    logic signed [35:0] r_it_c  [AXES];
    logic signed [35:0] r_it_d  [AXES];
    logic [3:0]         n_it_k;
    logic signed [31:0] n_it_p0 [AXES];
    logic signed [31:0] n_it_t0 [AXES];
    logic signed [35:0] n_it_c  [AXES];
    logic signed [35:0] n_it_d  [AXES];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // Stage 1: weighted terms.
    logic signed [47:0] r_s1_pw [AXES];
    logic signed [47:0] r_s1_tw [AXES];
    logic signed [47:0] r_s1_cw [AXES];
    logic signed [47:0] r_s1_dw [AXES];
    logic               r_s1_ctl;
    logic signed [47:0] n_s1_pw [AXES];
    logic signed [47:0] n_s1_tw [AXES];
    logic signed [47:0] n_s1_cw [AXES];
    logic signed [47:0] n_s1_dw [AXES];
    t_weights           wts;

    // Stage 2: sign, saturation and the shifted magnitude split in halves.
    logic               r_s2_neg [AXES];
    logic               r_s2_sat [AXES];
    logic [18:0]        r_s2_hi  [AXES];
    logic [18:0]        r_s2_lo  [AXES];
    logic               r_s2_ctl;
    logic               n_s2_neg [AXES];
    logic               n_s2_sat [AXES];
    logic [18:0]        n_s2_hi  [AXES];
    logic [18:0]        n_s2_lo  [AXES];

    // Stage 3: reciprocal product of the upper half.
    logic [38:0]        r_s3_prod [AXES];
    logic               r_s3_neg  [AXES];
    logic               r_s3_sat  [AXES];
    logic [18:0]        r_s3_hi   [AXES];
    logic [18:0]        r_s3_lo   [AXES];
    logic               r_s3_ctl;

    // Stage 4: upper quotient and the remainder joined with the lower half.
    logic [12:0]        r_s4_qh  [AXES];
    logic [25:0]        r_s4_rem [AXES];
    logic               r_s4_neg [AXES];
    logic               r_s4_sat [AXES];
    logic               r_s4_ctl;
    logic [12:0]        n_s4_qh  [AXES];
    logic [25:0]        n_s4_rem [AXES];

    // Stage 5: reciprocal product of the remainder.
    logic [52:0]        r_s5_prod [AXES];
    logic [12:0]        r_s5_qh   [AXES];
    logic [25:0]        r_s5_rem  [AXES];
    logic               r_s5_neg  [AXES];
    logic               r_s5_sat  [AXES];
    logic               r_s5_ctl;

    // Stage 6: output register.
    logic signed [31:0] r_s6_val [AXES];
    logic               r_s6_ctl;
    logic signed [31:0] n_s6_val [AXES];

    assign in_pos[0] = i_in_data.pos_x;
    assign in_pos[1] = i_in_data.pos_y;
    assign in_pos[2] = i_in_data.pos_z;
    assign in_tan[0] = i_in_data.tan_x;
    assign in_tan[1] = i_in_data.tan_y;
    assign in_tan[2] = i_in_data.tan_z;

    assign rdy6 = !r_v6 || i_out_ready;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign issue      = r_it_valid && rdy1;
    assign issue_last = issue && (r_it_k == LAST_IDX);
    assign o_in_ready = !r_it_valid || (rdy1 && (r_it_k == LAST_IDX));
    assign in_xfer    = i_in_valid && o_in_ready;
    assign seg        = !i_in_data.start_curve && r_have_prev;

    // Segment setup. A start point runs only the control sample with P0 = P1 and
    // zero coefficients, which reproduces the point exactly.
    always_comb begin
        logic signed [35:0] pe, pp, te, tp, df;
        n_it_k = seg ? 4'd0 : LAST_IDX;
        for (int a = 0; a < AXES; a++) begin
            pe = 36'(in_pos[a]);
            pp = 36'(r_prev_pos[a]);
            te = 36'(in_tan[a]);
            tp = 36'(r_prev_tan[a]);
            df = pe - pp;
            if (seg) begin
                n_it_p0[a] = r_prev_pos[a];
                n_it_t0[a] = r_prev_tan[a];
                n_it_c[a]  = (df <<< 1) + df - te - (tp <<< 1);
                n_it_d[a]  = te + tp - (df <<< 1);
            end else begin
                n_it_p0[a] = in_pos[a];
                n_it_t0[a] = '0;
                n_it_c[a]  = '0;
                n_it_d[a]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_valid  <= 1'b0;
            r_it_k      <= '0;
            r_have_prev <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_prev_pos[a] <= '0;
                r_prev_tan[a] <= '0;
            end
        end else begin
            if (in_xfer) begin
                r_it_valid  <= 1'b1;
                r_it_k      <= n_it_k;
                r_have_prev <= 1'b1;
                for (int a = 0; a < AXES; a++) begin
                    r_prev_pos[a] <= in_pos[a];
                    r_prev_tan[a] <= in_tan[a];
                end
            end else if (issue_last) begin
                r_it_valid <= 1'b0;
            end else if (issue) begin
                r_it_k <= r_it_k + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int a = 0; a < AXES; a++) begin
                r_it_p0[a] <= n_it_p0[a];
                r_it_t0[a] <= n_it_t0[a];
                r_it_c[a]  <= n_it_c[a];
                r_it_d[a]  <= n_it_d[a];
            end
        end
    end

    // Combinational arithmetic for stages 1, 2, 4 and 6, one lane per axis.
    always_comb begin
        logic signed [47:0] sum;
        logic [47:0]        mag;
        logic [47:0]        m;
        logic [12:0]        qh_est;
        logic [18:0]        rh;
        logic [18:0]        ql_est;
        logic [18:0]        ql;
        logic [25:0]        rl;
        logic [31:0]        q;
        wts = hcs_weights(r_it_k);
        for (int a = 0; a < AXES; a++) begin
            n_s1_pw[a] = 48'(r_it_p0[a]) * WEIGHT_P0;
            n_s1_tw[a] = 48'(r_it_t0[a]) * $signed(48'(wts.w1));
            n_s1_cw[a] = 48'(r_it_c[a])  * $signed(48'(wts.w2));
            n_s1_dw[a] = 48'(r_it_d[a])  * $signed(48'(wts.w3));

            // Round to nearest with ties away from zero on the magnitude.
            sum         = r_s1_pw[a] + r_s1_tw[a] + r_s1_cw[a] + r_s1_dw[a];
            mag         = sum[47] ? 48'(-sum) : 48'(sum);
            m           = mag + ROUND_HALF;
            n_s2_neg[a] = sum[47];
            n_s2_sat[a] = sum[47] ? (m >= SAT_NEG) : (m >= SAT_POS);
            n_s2_hi[a]  = m[40:22];
            n_s2_lo[a]  = m[21:3];

            // The reciprocal estimate is low by at most one.
            qh_est = r_s3_prod[a][38:26];
            rh     = r_s3_hi[a] - 19'(qh_est) * 19'(DIV_Q);
            if (rh >= 19'(DIV_Q)) begin
                n_s4_qh[a]  = qh_est + 13'd1;
                n_s4_rem[a] = {7'(rh - 19'(DIV_Q)), r_s3_lo[a]};
            end else begin
                n_s4_qh[a]  = qh_est;
                n_s4_rem[a] = {rh[6:0], r_s3_lo[a]};
            end

            ql_est = r_s5_prod[a][51:33];
            rl     = r_s5_rem[a] - 26'(ql_est) * 26'(DIV_Q);
            ql     = (rl >= 26'(DIV_Q)) ? ql_est + 19'd1 : ql_est;
            q      = {r_s5_qh[a], ql};
            if (r_s5_sat[a]) begin
                n_s6_val[a] = r_s5_neg[a] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_s6_val[a] = r_s5_neg[a] ? $signed(-q) : $signed(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= issue;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_ctl <= (r_it_k == LAST_IDX);
            for (int a = 0; a < AXES; a++) begin
                r_s1_pw[a] <= n_s1_pw[a];
                r_s1_tw[a] <= n_s1_tw[a];
                r_s1_cw[a] <= n_s1_cw[a];
                r_s1_dw[a] <= n_s1_dw[a];
            end
        end
        if (rdy2) begin
            r_s2_ctl <= r_s1_ctl;
            for (int a = 0; a < AXES; a++) begin
                r_s2_neg[a] <= n_s2_neg[a];
                r_s2_sat[a] <= n_s2_sat[a];
                r_s2_hi[a]  <= n_s2_hi[a];
                r_s2_lo[a]  <= n_s2_lo[a];
            end
        end
        if (rdy3) begin
            r_s3_ctl <= r_s2_ctl;
            for (int a = 0; a < AXES; a++) begin
                r_s3_prod[a] <= 39'(r_s2_hi[a]) * 39'(R1);
                r_s3_neg[a]  <= r_s2_neg[a];
                r_s3_sat[a]  <= r_s2_sat[a];
                r_s3_hi[a]   <= r_s2_hi[a];
                r_s3_lo[a]   <= r_s2_lo[a];
            end
        end
        if (rdy4) begin
            r_s4_ctl <= r_s3_ctl;
            for (int a = 0; a < AXES; a++) begin
                r_s4_qh[a]  <= n_s4_qh[a];
                r_s4_rem[a] <= n_s4_rem[a];
                r_s4_neg[a] <= r_s3_neg[a];
                r_s4_sat[a] <= r_s3_sat[a];
            end
        end
        if (rdy5) begin
            r_s5_ctl <= r_s4_ctl;
            for (int a = 0; a < AXES; a++) begin
                r_s5_prod[a] <= 53'(r_s4_rem[a]) * 53'(R2);
                r_s5_qh[a]   <= r_s4_qh[a];
                r_s5_rem[a]  <= r_s4_rem[a];
                r_s5_neg[a]  <= r_s4_neg[a];
                r_s5_sat[a]  <= r_s4_sat[a];
            end
        end
        if (rdy6) begin
            r_s6_ctl <= r_s5_ctl;
            for (int a = 0; a < AXES; a++) begin
                r_s6_val[a] <= n_s6_val[a];
            end
        end
    end

    assign o_out_valid            = r_v6;
    assign o_out_data.out_x       = r_s6_val[0];
    assign o_out_data.out_y       = r_s6_val[1];
    assign o_out_data.out_z       = r_s6_val[2];
    assign o_out_data.is_control  = r_s6_ctl;
    assign o_out_data.last_of_run = r_s6_ctl;

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_it_valid |-> (r_it_k <= LAST_IDX))
        else $error("sample index ran past the control sample");

    a_start_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !seg) |=> (r_it_valid && (r_it_k == LAST_IDX)))
        else $error("start point did not go straight to its control sample");

    a_segment_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && seg) |=> (r_it_valid && (r_it_k == 4'd0)))
        else $error("segment point did not begin at the first interior sample");

    a_prev_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_have_prev)
        else $error("previous point not recorded after a transfer");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue_last |=> (r_v1 && r_s1_ctl))
        else $error("control sample entered the pipeline unmarked");

endmodule
